### hdl/bbpm_pkg.sv
package bbpm_pkg;

  localparam int SLOTS       = 256;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int SPACE       = 4096;
  localparam int ID_W        = 12;
  localparam int DIR_W       = SLOT_W + 1;
  localparam int STACK_DEPTH = 256;
  localparam int STK_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = STK_W + 1;
  localparam int NNB_W       = 13;

  localparam logic [DIR_W-1:0] NOT_RES = DIR_W'(SLOTS);

  localparam logic [2:0] CMD_ALLOC   = 3'd0;
  localparam logic [2:0] CMD_READ    = 3'd1;
  localparam logic [2:0] CMD_SAVE    = 3'd2;
  localparam logic [2:0] CMD_RELEASE = 3'd3;
  localparam logic [2:0] CMD_DESTROY = 3'd4;

  localparam logic [2:0] ERR_OK         = 3'd0;
  localparam logic [2:0] ERR_NO_SLOT    = 3'd1;
  localparam logic [2:0] ERR_NOT_RES    = 3'd2;
  localparam logic [2:0] ERR_DOUBLE     = 3'd3;
  localparam logic [2:0] ERR_STACK      = 3'd4;
  localparam logic [2:0] ERR_SPACE      = 3'd5;
  localparam logic [2:0] ERR_DIRTY_READ = 3'd6;

  typedef enum logic [2:0] {
    ST_EMPTY  = 3'd0,
    ST_USED   = 3'd1,
    ST_UNUSED = 3'd2,
    ST_DIRTY  = 3'd3,
    ST_FDIRTY = 3'd4
  } slot_st_t;

  typedef struct packed {
    logic       capture;
    logic       wipe;
    logic       dir_rd_id;
    logic       use_stack;
    logic       key_nnb;
    logic       key_stk;
    logic       key_id;
    logic       st_rd_probe;
    logic       probe_step;
    logic       st_rd_dir;
    logic       st_wr_dir;
    slot_st_t   st_val;
    logic       blk_rd;
    logic       dir_rd_blk;
    logic       dir_clr_blk;
    logic       place;
    logic       destroy;
    logic       err;
    logic [2:0] err_val;
    logic       res_slot_dir;
    logic       finish;
  } ctrl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       fsc_zero;
    logic       fsc_full;
    logic       nnb_ok;
    logic       resident;
    slot_st_t   st;
    logic       probe_last;
    logic       wipe_last;
    logic       out_free;
  } stat_t;

endpackage

### hdl/bbpm_ctrl.sv
module bbpm_ctrl import bbpm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output ctrl_t ctrl
);

  typedef enum logic [12:0] {
    S_WIPE      = 13'b0000000000001,
    S_IDLE      = 13'b0000000000010,
    S_DECODE    = 13'b0000000000100,
    S_POP       = 13'b0000000001000,
    S_DIR       = 13'b0000000010000,
    S_RES       = 13'b0000000100000,
    S_PROBE_RD  = 13'b0000001000000,
    S_PROBE_CHK = 13'b0000010000000,
    S_EV_BLK    = 13'b0000100000000,
    S_EV_CLR    = 13'b0001000000000,
    S_PLACE     = 13'b0010000000000,
    S_DONE      = 13'b0100000000000,
    S_SPARE     = 13'b1000000000000
  } state_t;

  state_t state, state_next;
  logic   slot_free;

  assign in_stall  = (state != S_IDLE);
  assign slot_free = (stat.st == ST_EMPTY) || (stat.st == ST_UNUSED) || (stat.st == ST_FDIRTY);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_WIPE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    ctrl       = '0;
    state_next = state;
    case (state)
      S_WIPE: begin
        ctrl.wipe = 1'b1;
        if (stat.wipe_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          ctrl.capture = 1'b1;
          state_next   = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.cmd)
          CMD_ALLOC: begin
            if (!stat.fsc_zero) begin
              ctrl.use_stack = 1'b1;
              state_next     = S_POP;
            end else if (stat.nnb_ok) begin
              ctrl.key_nnb = 1'b1;
              state_next   = S_PROBE_RD;
            end else begin
              ctrl.err     = 1'b1;
              ctrl.err_val = ERR_SPACE;
              state_next   = S_DONE;
            end
          end
          CMD_READ, CMD_SAVE, CMD_RELEASE, CMD_DESTROY: begin
            ctrl.dir_rd_id = 1'b1;
            state_next     = S_DIR;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_POP: begin
        ctrl.key_stk = 1'b1;
        state_next   = S_PROBE_RD;
      end
      S_DIR: begin
        state_next = S_DONE;
        case (stat.cmd)
          CMD_READ: begin
            if (stat.resident) begin
              ctrl.st_rd_dir = 1'b1;
              state_next     = S_RES;
            end else begin
              ctrl.key_id = 1'b1;
              state_next  = S_PROBE_RD;
            end
          end
          CMD_SAVE: begin
            if (stat.resident) begin
              ctrl.st_wr_dir    = 1'b1;
              ctrl.st_val       = ST_DIRTY;
              ctrl.res_slot_dir = 1'b1;
            end else begin
              ctrl.err     = 1'b1;
              ctrl.err_val = ERR_NOT_RES;
            end
          end
          CMD_RELEASE: begin
            if (stat.resident) begin
              ctrl.st_rd_dir = 1'b1;
              state_next     = S_RES;
            end else begin
              ctrl.err     = 1'b1;
              ctrl.err_val = ERR_NOT_RES;
            end
          end
          default: begin
            if (stat.fsc_full) begin
              ctrl.err     = 1'b1;
              ctrl.err_val = ERR_STACK;
            end else begin
              ctrl.destroy = 1'b1;
              if (stat.resident) begin
                ctrl.st_wr_dir = 1'b1;
                ctrl.st_val    = ST_EMPTY;
              end
            end
          end
        endcase
      end
      S_RES: begin
        state_next        = S_DONE;
        ctrl.res_slot_dir = 1'b1;
        if (stat.cmd == CMD_READ) begin
          if (stat.st == ST_DIRTY) begin
            ctrl.err     = 1'b1;
            ctrl.err_val = ERR_DIRTY_READ;
          end else begin
            ctrl.st_wr_dir = 1'b1;
            ctrl.st_val    = (stat.st == ST_FDIRTY) ? ST_DIRTY : ST_USED;
          end
        end else begin
          if (stat.st == ST_UNUSED || stat.st == ST_FDIRTY) begin
            ctrl.res_slot_dir = 1'b0;
            ctrl.err          = 1'b1;
            ctrl.err_val      = ERR_DOUBLE;
          end else begin
            ctrl.st_wr_dir = 1'b1;
            ctrl.st_val    = (stat.st == ST_DIRTY) ? ST_FDIRTY : ST_UNUSED;
          end
        end
      end
      S_PROBE_RD: begin
        ctrl.st_rd_probe = 1'b1;
        state_next       = S_PROBE_CHK;
      end
      S_PROBE_CHK: begin
        if (slot_free) begin
          if (stat.st == ST_EMPTY) begin
            state_next = S_PLACE;
          end else begin
            ctrl.blk_rd = 1'b1;
            state_next  = S_EV_BLK;
          end
        end else if (stat.probe_last) begin
          ctrl.err     = 1'b1;
          ctrl.err_val = ERR_NO_SLOT;
          state_next   = S_DONE;
        end else begin
          ctrl.probe_step = 1'b1;
          state_next      = S_PROBE_RD;
        end
      end
      S_EV_BLK: begin
        ctrl.dir_rd_blk = 1'b1;
        state_next      = S_EV_CLR;
      end
      S_EV_CLR: begin
        ctrl.dir_clr_blk = 1'b1;
        state_next       = S_PLACE;
      end
      S_PLACE: begin
        ctrl.place = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          ctrl.finish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### hdl/bbpm_datapath.sv
module bbpm_datapath import bbpm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  ctrl_t             ctrl,
  output stat_t             stat,
  input  logic [2:0]        command,
  input  logic [ID_W-1:0]   block_id,
  input  logic              cfg_we,
  input  logic [NNB_W-1:0]  initial_block_count,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [SLOT_W-1:0] slot,
  output logic [ID_W-1:0]   result_block,
  output logic              writeback_needed,
  output logic [ID_W-1:0]   writeback_block,
  output logic              fetch_needed,
  output logic              zero_fill,
  output logic [2:0]        error_code
);

  logic [DIR_W-1:0] dir_mem [SPACE];
  slot_st_t         st_mem  [SLOTS];
  logic             st_vld  [SLOTS];
  logic [ID_W-1:0]  blk_mem [SLOTS];
  logic [ID_W-1:0]  stk_mem [STACK_DEPTH];

  logic [2:0]        cmd_q;
  logic [ID_W-1:0]   id_q, key_q, key_next;
  logic              from_stack;
  logic [SLOT_W-1:0] probe_s, probe_n;
  logic [CNT_W-1:0]  fsc, fsc_m1;
  logic [NNB_W-1:0]  nnb;
  logic [ID_W-1:0]   wipe_cnt;
  logic [DIR_W-1:0]  dir_q;
  slot_st_t          st_q;
  logic              st_vq;
  logic [ID_W-1:0]   blk_q, stk_q;
  logic              ev_fdirty;

  logic [SLOT_W-1:0] r_slot;
  logic [ID_W-1:0]   r_block, r_wbblk;
  logic              r_wb, r_fetch, r_zero;
  logic [2:0]        r_err;

  logic              resident, key_load, alloc_q;
  logic [SLOT_W-1:0] dir_slot, st_ra;
  logic              dir_we, dir_re, st_we, st_re;
  logic [ID_W-1:0]   dir_wa, dir_ra;
  logic [DIR_W-1:0]  dir_wd;
  logic [SLOT_W-1:0] st_wa;
  slot_st_t          st_wd;

  assign resident = dir_q < DIR_W'(SLOTS);
  assign dir_slot = dir_q[SLOT_W-1:0];
  assign fsc_m1   = fsc - 1'b1;
  assign alloc_q  = (cmd_q == CMD_ALLOC);
  assign key_load = ctrl.key_nnb | ctrl.key_stk | ctrl.key_id;

  always_comb begin
    key_next = key_q;
    if (ctrl.key_nnb) key_next = nnb[ID_W-1:0];
    if (ctrl.key_stk) key_next = stk_q;
    if (ctrl.key_id)  key_next = id_q;
  end

  always_comb begin
    dir_we = 1'b0;
    dir_wa = key_q;
    dir_wd = NOT_RES;
    if (ctrl.wipe) begin
      dir_we = 1'b1;
      dir_wa = wipe_cnt;
    end else if (ctrl.dir_clr_blk && dir_q == {1'b0, probe_s}) begin
      // only clear if the directory still points at the slot being evicted
      dir_we = 1'b1;
      dir_wa = blk_q;
    end else if (ctrl.place) begin
      dir_we = 1'b1;
      dir_wd = {1'b0, probe_s};
    end else if (ctrl.destroy && resident) begin
      dir_we = 1'b1;
      dir_wa = id_q;
    end
  end

  assign dir_re = ctrl.dir_rd_id | ctrl.dir_rd_blk;
  assign dir_ra = ctrl.dir_rd_blk ? blk_q : id_q;

  always_ff @(posedge clk) begin
    if (dir_we) dir_mem[dir_wa] <= dir_wd;
    if (dir_re) dir_q <= dir_mem[dir_ra];
  end

  assign st_we = ctrl.place | ctrl.st_wr_dir;
  assign st_wa = ctrl.place ? probe_s : dir_slot;
  assign st_wd = ctrl.place ? ST_USED : ctrl.st_val;
  assign st_re = ctrl.st_rd_probe | ctrl.st_rd_dir;
  assign st_ra = ctrl.st_rd_probe ? probe_s : dir_slot;

  always_ff @(posedge clk) begin
    if (st_we) st_mem[st_wa] <= st_wd;
    if (st_re) begin
      st_q  <= st_mem[st_ra];
      st_vq <= st_vld[st_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) st_vld[i] <= 1'b0;
    end else if (st_we) begin
      st_vld[st_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.place) blk_mem[probe_s] <= key_q;
    if (ctrl.blk_rd) begin
      blk_q     <= blk_mem[probe_s];
      ev_fdirty <= (st_vq ? st_q : ST_EMPTY) == ST_FDIRTY;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.destroy) stk_mem[fsc[STK_W-1:0]] <= id_q;
    if (ctrl.use_stack) stk_q <= stk_mem[fsc_m1[STK_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsc      <= '0;
      nnb      <= '0;
      wipe_cnt <= '0;
    end else begin
      if (ctrl.wipe) wipe_cnt <= wipe_cnt + 1'b1;
      if (ctrl.destroy) begin
        fsc <= fsc + 1'b1;
      end else if (ctrl.place && alloc_q && from_stack) begin
        fsc <= fsc_m1;
      end
      if (cfg_we) begin
        nnb <= initial_block_count;
      end else if (ctrl.place && alloc_q && !from_stack) begin
        nnb <= nnb + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_q <= command;
      id_q  <= block_id;
    end
    if (key_load) begin
      key_q      <= key_next;
      from_stack <= ctrl.key_stk;
      probe_s    <= key_next[SLOT_W-1:0];
      probe_n    <= '0;
    end else if (ctrl.probe_step) begin
      probe_s <= probe_s + 1'b1;
      probe_n <= probe_n + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      r_slot  <= '0;
      r_block <= (command >= CMD_READ && command <= CMD_DESTROY) ? block_id : '0;
      r_wb    <= 1'b0;
      r_wbblk <= '0;
      r_fetch <= 1'b0;
      r_zero  <= 1'b0;
      r_err   <= ERR_OK;
    end else begin
      if (ctrl.err) r_err <= ctrl.err_val;
      if (ctrl.res_slot_dir || (ctrl.destroy && resident)) r_slot <= dir_slot;
      if (ctrl.dir_rd_blk && ev_fdirty) begin
        r_wb    <= 1'b1;
        r_wbblk <= blk_q;
      end
      if (ctrl.place) begin
        r_slot  <= probe_s;
        r_block <= key_q;
        r_zero  <= alloc_q;
        r_fetch <= (cmd_q == CMD_READ);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      slot             <= r_slot;
      result_block     <= r_block;
      writeback_needed <= r_wb;
      writeback_block  <= r_wbblk;
      fetch_needed     <= r_fetch;
      zero_fill        <= r_zero;
      error_code       <= r_err;
    end
  end

  assign stat.cmd        = cmd_q;
  assign stat.fsc_zero   = (fsc == '0);
  assign stat.fsc_full   = (fsc >= CNT_W'(STACK_DEPTH));
  assign stat.nnb_ok     = (nnb < NNB_W'(SPACE));
  assign stat.resident   = resident;
  assign stat.st         = st_vq ? st_q : ST_EMPTY;
  assign stat.probe_last = (probe_n == SLOT_W'(SLOTS - 1));
  assign stat.wipe_last  = (wipe_cnt == ID_W'(SPACE - 1));
  assign stat.out_free   = !out_valid || !out_stall;

endmodule

### hdl/block_buffer_pool_manager.sv
// Result paths: an unknown command or an allocate with no block space left goes straight
// to the result; save, destroy and not-resident errors pass the directory read; a resident
// read or release also reads the slot state. An allocate (from counter or free stack) or a
// read miss probes slots in turn from the first, checking up to 255 further slots, and may
// evict. One item at a time; the next beat is taken the cycle after the result is loaded.
// After reset a pass that clears all 4096 directory entries stalls the input.
module block_buffer_pool_manager import bbpm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        command,
  input  logic [ID_W-1:0]   block_id,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [NNB_W-1:0]  initial_block_count,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SLOT_W-1:0] slot,
  output logic [ID_W-1:0]   result_block,
  output logic              writeback_needed,
  output logic [ID_W-1:0]   writeback_block,
  output logic              fetch_needed,
  output logic              zero_fill,
  output logic [2:0]        error_code
);

  ctrl_t ctrl;
  stat_t stat;

  assign cfg_ready = 1'b1;

  bbpm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  bbpm_datapath u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .ctrl                (ctrl),
    .stat                (stat),
    .command             (command),
    .block_id            (block_id),
    .cfg_we              (cfg_valid && cfg_ready),
    .initial_block_count (initial_block_count),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .slot                (slot),
    .result_block        (result_block),
    .writeback_needed    (writeback_needed),
    .writeback_block     (writeback_block),
    .fetch_needed        (fetch_needed),
    .zero_fill           (zero_fill),
    .error_code          (error_code)
  );

  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while an item is in flight");

  a_err_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> error_code <= ERR_DIRTY_READ)
    else $error("error code out of range");

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error_code != ERR_OK) |-> (!writeback_needed && !zero_fill && !fetch_needed))
    else $error("side effect flagged on failed command");

endmodule

### test/tb.sv
module tb;
  import bbpm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [7:0]  slot;
    logic [11:0] blk;
    logic        wb;
    logic [11:0] wb_blk;
    logic        fetch;
    logic        zfill;
    logic [2:0]  err;
  } pool_res_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [11:0] id;
    logic        fixed;
    pool_res_t   res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic [2:0] command = CMD_ALLOC;
  logic [ID_W-1:0] block_id = '0;
  logic cfg_valid = 1'b0;
  logic [NNB_W-1:0] initial_block_count = '0;
  logic out_stall = 1'b0;
  logic in_stall, cfg_ready, out_valid;
  logic [SLOT_W-1:0] slot;
  logic [ID_W-1:0] result_block, writeback_block;
  logic writeback_needed, fetch_needed, zero_fill;
  logic [2:0] error_code;

  block_buffer_pool_manager DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .block_id(block_id),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .initial_block_count(initial_block_count),
    .out_valid(out_valid), .out_stall(out_stall),
    .slot(slot), .result_block(result_block),
    .writeback_needed(writeback_needed), .writeback_block(writeback_block),
    .fetch_needed(fetch_needed), .zero_fill(zero_fill),
    .error_code(error_code)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // pool mirror
  slot_st_t    slot_state[SLOTS];
  logic [11:0] slot_owner[SLOTS];
  int          dir_slot[SPACE];
  logic [11:0] freed_ids[STACK_DEPTH];
  int          freed_cnt;
  int          next_blk;

  pool_res_t result_q[$];
  int        fail_cnt = 0;
  int        burst_left = 0;

  function automatic int probe_slot(int id);
    int s;
    s = id % SLOTS;
    for (int n = 0; n < SLOTS; n++) begin
      if (slot_state[s] inside {ST_EMPTY, ST_UNUSED, ST_FDIRTY}) return s;
      s = (s + 1) % SLOTS;
    end
    return SLOTS;
  endfunction

  function automatic void take_slot(int s, int id, inout pool_res_t r);
    int b;
    if (slot_state[s] != ST_EMPTY) begin
      b = slot_owner[s];
      if (slot_state[s] == ST_FDIRTY) begin
        r.wb = 1'b1;
        r.wb_blk = slot_owner[s];
      end
      if (dir_slot[b] == s) dir_slot[b] = SLOTS;
    end
    slot_state[s] = ST_USED;
    slot_owner[s] = 12'(id);
    dir_slot[id] = s;
  endfunction

  function automatic pool_res_t pool_step(logic [2:0] cmd, logic [11:0] id);
    pool_res_t r;
    int s, nid;
    bit pop;
    r = '0;
    if (cmd > CMD_DESTROY) return r;
    if (cmd == CMD_ALLOC) begin
      if (freed_cnt > 0) begin
        nid = freed_ids[freed_cnt-1];
        pop = 1;
      end else if (next_blk < SPACE) begin
        nid = next_blk;
        pop = 0;
      end else begin
        r.err = ERR_SPACE;
        return r;
      end
      s = probe_slot(nid);
      if (s >= SLOTS) begin
        r.err = ERR_NO_SLOT;
        return r;
      end
      if (pop) freed_cnt--;
      else next_blk++;
      take_slot(s, nid, r);
      r.slot = 8'(s);
      r.blk = 12'(nid);
      r.zfill = 1'b1;
      return r;
    end
    r.blk = id;
    s = dir_slot[id];
    case (cmd)
      CMD_READ: begin
        if (s >= SLOTS) begin
          s = probe_slot(id);
          if (s >= SLOTS) begin
            r.err = ERR_NO_SLOT;
            return r;
          end
          take_slot(s, id, r);
          r.slot = 8'(s);
          r.fetch = 1'b1;
        end else begin
          r.slot = 8'(s);
          if (slot_state[s] == ST_DIRTY) r.err = ERR_DIRTY_READ;
          else slot_state[s] = (slot_state[s] == ST_FDIRTY) ? ST_DIRTY : ST_USED;
        end
      end
      CMD_DESTROY: begin
        if (freed_cnt >= STACK_DEPTH) begin
          r.err = ERR_STACK;
          return r;
        end
        freed_ids[freed_cnt] = id;
        freed_cnt++;
        if (s < SLOTS) begin
          slot_state[s] = ST_EMPTY;
          dir_slot[id] = SLOTS;
          r.slot = 8'(s);
        end
      end
      default: begin
        if (s >= SLOTS) r.err = ERR_NOT_RES;
        else if (cmd == CMD_SAVE) begin
          slot_state[s] = ST_DIRTY;
          r.slot = 8'(s);
        end else if (slot_state[s] inside {ST_UNUSED, ST_FDIRTY}) begin
          r.err = ERR_DOUBLE;
        end else begin
          slot_state[s] = (slot_state[s] == ST_DIRTY) ? ST_FDIRTY : ST_UNUSED;
          r.slot = 8'(s);
        end
      end
    endcase
    return r;
  endfunction

  // one beat; table rows with a typed result override the mirror's answer
  task automatic send_cmd(logic [2:0] cmd, logic [11:0] id, bit fixed = 0,
                          pool_res_t typed = '0);
    pool_res_t r;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid <= 1'b1;
    command <= cmd;
    block_id <= id;
    do @(posedge clk); while (in_stall);
    r = pool_step(cmd, id);
    result_q.push_back(fixed ? typed : r);
    @(negedge clk);
  endtask

  task automatic write_count(logic [NNB_W-1:0] v);
    in_valid <= 1'b0;
    burst_left = 0;
    wait (result_q.size() == 0);
    @(negedge clk);
    cfg_valid <= 1'b1;
    initial_block_count <= v;
    do @(posedge clk); while (!cfg_ready);
    next_blk = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [11:0] pick_id();
    // low ids in several 256-aliased groups so probes collide
    if ($urandom_range(0, 9) < 7) return 12'(($urandom_range(0, 15) << 8) | $urandom_range(0, 11));
    return 12'($urandom_range(0, 4095));
  endfunction

  function automatic logic [2:0] pick_cmd();
    int p;
    p = $urandom_range(0, 99);
    if (p < 20) return CMD_ALLOC;
    if (p < 45) return CMD_READ;
    if (p < 60) return CMD_SAVE;
    if (p < 80) return CMD_RELEASE;
    if (p < 95) return CMD_DESTROY;
    return 3'($urandom_range(5, 7));
  endfunction

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) send_cmd(pick_cmd(), pick_id());
  endtask

  row_t dir_rows[] = '{
    '{CMD_READ,    12'd4095, 1, '{8'd255, 12'd4095, 0, 0, 1, 0, ERR_OK}},
    '{CMD_ALLOC,   12'd0,    1, '{8'd0, 12'd0, 0, 0, 0, 1, ERR_OK}},
    '{CMD_SAVE,    12'd0,    1, '{8'd0, 12'd0, 0, 0, 0, 0, ERR_OK}},
    '{CMD_READ,    12'd0,    1, '{8'd0, 12'd0, 0, 0, 0, 0, ERR_DIRTY_READ}},
    '{CMD_RELEASE, 12'd0,    0, '0},
    '{CMD_RELEASE, 12'd0,    1, '{8'd0, 12'd0, 0, 0, 0, 0, ERR_DOUBLE}},
    '{CMD_READ,    12'd0,    0, '0},
    '{CMD_RELEASE, 12'd0,    0, '0},
    '{CMD_READ,    12'd256,  1, '{8'd0, 12'd256, 1, 12'd0, 1, 0, ERR_OK}},
    '{CMD_SAVE,    12'd5,    1, '{8'd0, 12'd5, 0, 0, 0, 0, ERR_NOT_RES}},
    '{CMD_RELEASE, 12'd7,    1, '{8'd0, 12'd7, 0, 0, 0, 0, ERR_NOT_RES}},
    '{CMD_DESTROY, 12'd256,  0, '0},
    '{CMD_DESTROY, 12'd4095, 0, '0},
    '{CMD_ALLOC,   12'd0,    0, '0},
    '{3'd5,        12'd4095, 1, '0},
    '{3'd6,        12'd4095, 1, '0},
    '{3'd7,        12'd4095, 1, '0},
    '{CMD_ALLOC,   12'd0,    0, '0},
    '{CMD_DESTROY, 12'd1000, 0, '0},
    '{CMD_READ,    12'd2048, 0, '0},
    '{CMD_RELEASE, 12'd2048, 0, '0},
    '{CMD_READ,    12'd0,    0, '0},
    '{CMD_SAVE,    12'd4095, 0, '0},
    '{CMD_RELEASE, 12'd4095, 0, '0},
    '{CMD_ALLOC,   12'd0,    0, '0}
  };

  // receiver stall pattern: runs of free flow, light and heavy stalling
  int stall_mode = 0, stall_run = 0;
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_run == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_run = $urandom_range(10, 80);
      end
      stall_run--;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 9) < 6);
      endcase
    end
  end

  always @(posedge clk) begin
    pool_res_t e;
    if (!rst && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        $error("result beat with nothing expected");
        fail_cnt++;
      end else begin
        e = result_q.pop_front();
        if (slot !== e.slot) begin
          $error("slot: expected %0d, got %0d", e.slot, slot); fail_cnt++;
        end
        if (result_block !== e.blk) begin
          $error("result_block: expected %0d, got %0d", e.blk, result_block); fail_cnt++;
        end
        if (writeback_needed !== e.wb) begin
          $error("writeback_needed: expected %0d, got %0d", e.wb, writeback_needed);
          fail_cnt++;
        end
        if (writeback_block !== e.wb_blk) begin
          $error("writeback_block: expected %0d, got %0d", e.wb_blk, writeback_block);
          fail_cnt++;
        end
        if (fetch_needed !== e.fetch) begin
          $error("fetch_needed: expected %0d, got %0d", e.fetch, fetch_needed); fail_cnt++;
        end
        if (zero_fill !== e.zfill) begin
          $error("zero_fill: expected %0d, got %0d", e.zfill, zero_fill); fail_cnt++;
        end
        if (error_code !== e.err) begin
          $error("error_code: expected %0d, got %0d", e.err, error_code); fail_cnt++;
        end
      end
    end
  end

  // watchdog on beats of any channel
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_state[i] = ST_EMPTY;
      slot_owner[i] = '0;
    end
    for (int i = 0; i < SPACE; i++) dir_slot[i] = SLOTS;
    freed_cnt = 0;
    next_blk = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_count(13'd0);
    foreach (dir_rows[i]) send_cmd(dir_rows[i].cmd, dir_rows[i].id, dir_rows[i].fixed,
                                   dir_rows[i].res);
    run_random(40);

    // fill the free stack past full, then allocate from it
    write_count(13'd4096);
    for (int i = 0; i < 258; i++) send_cmd(CMD_DESTROY, 12'($urandom_range(0, 4095)));
    for (int i = 0; i < 80; i++) send_cmd(CMD_ALLOC, 12'($urandom_range(0, 4095)));
    for (int i = 0; i < 10; i++) send_cmd(CMD_RELEASE, pick_id());

    write_count(13'd8191);
    run_random(20);
    write_count(13'd4095);
    run_random(20);

    in_valid <= 1'b0;
    wait (result_q.size() == 0);
    repeat (600) @(posedge clk);
    if (fail_cnt == 0 && result_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
